>>> src/itoa_pkg.sv
package itoa_pkg;

   localparam int MaxCharsDefault = 64;

   localparam logic [6:0] FL_LEFT  = 7'h01;
   localparam logic [6:0] FL_PLUS  = 7'h02;
   localparam logic [6:0] FL_SPACE = 7'h04;
   localparam logic [6:0] FL_PREF  = 7'h08;
   localparam logic [6:0] FL_ZERO  = 7'h10;
   localparam logic [6:0] FL_LOWER = 7'h20;
   localparam logic [6:0] FL_SIGN  = 7'h40;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_XLOW  = 8'h78;
   localparam logic [7:0] CH_XUP   = 8'h58;

   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_MINUS = 2'd1;
   localparam logic [1:0] SIGN_PLUS  = 2'd2;
   localparam logic [1:0] SIGN_SPACE = 2'd3;

   typedef struct packed {
      logic signed [63:0] value;
      logic [4:0]         radix;
      logic signed [7:0]  field_width;
      logic signed [7:0]  min_digits;
      logic [6:0]         format_flags;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
      logic       truncated;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      logic [63:0] mag;
      logic [4:0]  radix;
      logic [7:0]  lead_sp;
      logic [1:0]  sign_sel;   // none, minus, plus or space
      logic [1:0]  plen;
      logic [7:0]  zero_pad;   // width zeros only, before digits; back adds precision zeros
      logic [7:0]  prec;       // precision as unsigned, 0 if none
      logic [7:0]  trail_sp;
      logic        lower;
   } job_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
      logic [7:0] c;
      if (d < 4'd10) c = 8'h30 + {4'd0, d};
      else if (lower) c = 8'h57 + {4'd0, d};
      else c = 8'h37 + {4'd0, d};
      return c;
   endfunction

endpackage

>>> src/itoa_front.sv
module itoa_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  itoa_pkg::req_type req_data,
   output logic              job_valid,
   output itoa_pkg::job_type job_data,
   input  logic              job_ready
);
   import itoa_pkg::*;

   logic    full_ff, full_in;
   job_type job_ff, job_in;
   logic [6:0] fl;
   logic    neg;
   logic    sgn;
   logic [1:0] plen;
   logic signed [9:0] w, p, fixed, pad;
   logic zp, left, ok;

   assign busy = full_ff;
   assign job_valid = full_ff;
   assign job_data = job_ff;
   assign ok = (req_data.radix >= 5'd2) && (req_data.radix <= 5'd16);

   always_comb begin
      fl = req_data.format_flags;
      left = fl[0];
      zp = fl[4] & ~left;
      neg = fl[6] & req_data.value[63];
      job_in = job_ff;
      job_in.mag = neg ? 64'd0 - req_data.value : req_data.value;
      job_in.radix = req_data.radix;
      job_in.lower = fl[5];
      if (!fl[6]) job_in.sign_sel = SIGN_NONE;
      else if (neg) job_in.sign_sel = SIGN_MINUS;
      else if (fl[1]) job_in.sign_sel = SIGN_PLUS;
      else if (fl[2]) job_in.sign_sel = SIGN_SPACE;
      else job_in.sign_sel = SIGN_NONE;
      sgn = job_in.sign_sel != SIGN_NONE;
      plen = 2'd0;
      if (fl[3]) begin
         if (req_data.radix == 5'd16) plen = 2'd2;
         else if (req_data.radix == 5'd8) plen = 2'd1;
      end
      job_in.plen = plen;
      w = {{2{req_data.field_width[7]}}, req_data.field_width};
      p = req_data.min_digits[7] ? 10'sd0 : {2'b0, req_data.min_digits};
      job_in.prec = p[7:0];
      // digit count is not known yet: the back part subtracts it
      fixed = {9'd0, sgn} + {8'd0, plen};
      pad = w - fixed;
      job_in.lead_sp = (!zp && !left && pad > 0) ? pad[7:0] : 8'd0;
      job_in.zero_pad = (zp && pad > 0) ? pad[7:0] : 8'd0;
      job_in.trail_sp = (left && pad > 0) ? pad[7:0] : 8'd0;
   end

   always_comb begin
      full_in = full_ff;
      if (full_ff && job_ready) full_in = 1'b0;
      if (start && !full_ff && ok) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      if (start && !full_ff) job_ff <= job_in;
   end
endmodule

>>> src/itoa_back.sv
module itoa_back #(
   parameter int MAX_CHARS = itoa_pkg::MaxCharsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  itoa_pkg::job_type job_data,
   output logic              job_ready,
   output logic              rsp_valid,
   output itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_PLAN = 3'd2, S_EMIT = 3'd3;

   logic [2:0] state_ff, state_in;
   job_type job_ff;
   logic [63:0] quo_ff;
   logic [3:0] rem_ff;
   logic [5:0] bit_ff;
   logic [63:0][3:0] dsh_ff;
   logic [6:0] nd_ff;
   logic [8:0] idx_ff, lsp_ff, pre_ff, zer_ff, dig_ff, tsp_ff;
   logic [8:0] tot;
   logic [4:0] part;
   logic [4:0] trial;
   logic qbit;
   logic [8:0] body;
   logic signed [10:0] adj;
   logic [8:0] pos;
   logic [7:0] ch;
   logic is_dig;
   logic [8:0] cap;

   assign job_ready = state_ff == S_IDLE;
   assign trial = {rem_ff, quo_ff[bit_ff]};
   assign qbit = trial >= job_ff.radix;
   assign cap = 9'(MAX_CHARS);
   assign tot = lsp_ff + pre_ff + zer_ff + dig_ff + tsp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (job_valid) state_in = S_DIV;
         S_DIV: if (bit_ff == 6'd0 && ((quo_ff[63:1] == 63'd0 && !qbit) || nd_ff == 7'd63))
            state_in = S_PLAN;
         S_PLAN: state_in = S_EMIT;
         S_EMIT: if (idx_ff + 9'd1 == tot || idx_ff + 9'd1 == cap) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      part = qbit ? trial - job_ff.radix : trial;
      body = (job_ff.prec > {1'b0, nd_ff}) ? {1'b0, job_ff.prec} : {2'b0, nd_ff};
      adj = $signed({3'b0, job_ff.zero_pad}) - $signed({2'b0, body});
      pos = idx_ff;
      ch = CH_SPACE;
      is_dig = 1'b0;
      if (pos < lsp_ff) ch = CH_SPACE;
      else if (pos < lsp_ff + pre_ff) begin
         pos = pos - lsp_ff;
         if (job_ff.sign_sel != SIGN_NONE && pos == 9'd0)
            ch = job_ff.sign_sel == SIGN_MINUS ? CH_MINUS :
                 job_ff.sign_sel == SIGN_PLUS ? CH_PLUS : CH_SPACE;
         else if (pos == pre_ff - 9'd1 && job_ff.plen == 2'd2)
            ch = job_ff.lower ? CH_XLOW : CH_XUP;
         else ch = CH_ZERO;
      end else if (pos < lsp_ff + pre_ff + zer_ff) ch = CH_ZERO;
      else if (pos < lsp_ff + pre_ff + zer_ff + dig_ff) begin
         ch = digit_char(dsh_ff[0], job_ff.lower);
         is_dig = 1'b1;
      end else ch = CH_SPACE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid <= state_ff == S_EMIT;
      end
      unique case (state_ff)
         S_IDLE: begin
            job_ff <= job_data;
            quo_ff <= job_data.mag;
            rem_ff <= 4'd0;
            bit_ff <= 6'd63;
            nd_ff <= 7'd0;
            idx_ff <= 9'd0;
         end
         S_DIV: begin
            // restoring division, one quotient bit a cycle
            quo_ff[bit_ff] <= qbit;
            if (bit_ff == 6'd0) begin
               dsh_ff <= {dsh_ff[62:0], part[3:0]};
               nd_ff <= nd_ff + 7'd1;
               bit_ff <= 6'd63;
               rem_ff <= 4'd0;
            end else begin
               rem_ff <= part[3:0];
               bit_ff <= bit_ff - 6'd1;
            end
         end
         S_PLAN: begin
            pre_ff <= {7'd0, job_ff.sign_sel != SIGN_NONE} + {7'd0, job_ff.plen};
            dig_ff <= {2'b0, nd_ff};
            zer_ff <= body - {2'b0, nd_ff} + (adj > 0 ? adj[8:0] : 9'd0);
            lsp_ff <= ($signed({3'b0, job_ff.lead_sp}) - $signed({2'b0, body})) > 0 ?
                      {1'b0, job_ff.lead_sp} - body : 9'd0;
            tsp_ff <= ($signed({3'b0, job_ff.trail_sp}) - $signed({2'b0, body})) > 0 ?
                      {1'b0, job_ff.trail_sp} - body : 9'd0;
         end
         S_EMIT: begin
            rsp_data.out_char <= ch;
            rsp_data.last_char <= state_in == S_IDLE;
            rsp_data.truncated <= state_in == S_IDLE && tot > cap;
            idx_ff <= idx_ff + 9'd1;
            if (is_dig) dsh_ff <= {4'd0, dsh_ff[63:1]};
         end
         default: ;
      endcase
   end
endmodule

>>> src/integer_to_ascii_formatter_core.sv
// Formats one 64-bit integer as printf does and sends its characters out one per cycle,
// last_char marking the final one. busy is high from start until the last character
// is on the result ports; the receiver cannot stall. Digits come from a bit-serial
// divider, and at most MAX_CHARS characters are sent.
module integer_to_ascii_formatter_core #(
   parameter int MAX_CHARS = itoa_pkg::MaxCharsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  itoa_pkg::req_type req_data,
   output logic              rsp_valid,
   output itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   logic f_busy, jv, jr;
   job_type jd;

   assign busy = f_busy | ~jr;

   itoa_front u_front (.clock, .reset, .start(start & ~busy), .busy(f_busy), .req_data,
      .job_valid(jv), .job_data(jd), .job_ready(jr));

   itoa_back #(.MAX_CHARS(MAX_CHARS)) u_back (.clock, .reset, .job_valid(jv),
      .job_data(jd), .job_ready(jr), .rsp_valid, .rsp_data);
endmodule

>>> src/itoa_checker.sv
module itoa_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input itoa_pkg::rsp_type rsp_data
);
   a_trunc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.truncated |-> rsp_data.last_char) else $error("trunc");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_valid || rsp_data.last_char) else $error("idle");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || !rsp_valid) else $error("busy");
endmodule

bind integer_to_ascii_formatter_core itoa_checker u_chk (.clock, .reset, .start, .busy,
   .rsp_valid, .rsp_data);
